// ===== rtl/core/fbecho_pkg.sv =====
// ----------------------------------------------------------------------------
// fbecho_pkg
// shared widths, register indexes, reset values and saturation helper for the
// feedback echo delay line
// ----------------------------------------------------------------------------
package fbecho_pkg;

   localparam int BufferDepthDefault = 8192;

   localparam int SampleW    = 16;
   localparam int DelayW     = 13;
   localparam int FeedbackW  = 15;
   localparam int MixW       = 16;
   localparam int CsrIndexW  = 4;
   localparam int CsrDataW   = 16;

   localparam int FeedbackLimit = 31130;
   localparam int MixFull       = 32768;

   localparam int DelayLengthRst  = 4096;
   localparam int FeedbackGainRst = 16384;
   localparam int MixLevelRst     = 16384;

   localparam logic [CsrIndexW-1:0] CSR_DELAY_LENGTH  = 4'd0;
   localparam logic [CsrIndexW-1:0] CSR_FEEDBACK_GAIN = 4'd1;
   localparam logic [CsrIndexW-1:0] CSR_MIX_LEVEL     = 4'd2;
   localparam logic [CsrIndexW-1:0] CSR_EFFECT_ENABLE = 4'd3;

   typedef logic signed [SampleW-1:0] sample_type;

   function automatic sample_type sat16(input logic signed [19:0] v);
      sample_type r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = sample_type'(v[15:0]);
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/fbecho_ram.sv =====
// ----------------------------------------------------------------------------
// fbecho_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module fbecho_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/feedback_echo_delay.sv =====
// ----------------------------------------------------------------------------
// feedback_echo_delay
// feedback delay line echo on a stream of signed q1.15 audio samples
// ----------------------------------------------------------------------------
// req_ carries one input sample per transaction, rsp_ one output sample per
// transaction, in the same order. csr_ writes the delay, feedback gain, mix
// level and enable registers; it is always ready and is to be written only while
// the block is idle, which the block itself does not enforce.
// An accepted sample passes through the multiply stage, the saturate stage and
// the output register, in that order, before its rsp transaction. The block takes
// one sample per cycle unless a blocked saturate stage or a read hazard holds it
// off. With a delay of one sample each sample needs the value stored by the one
// before it, so it is not taken while that one is still in the multiply stage;
// the block then cannot take a new sample before the last one has left that stage.
// The delay line lives in one ram with a registered read; the sample read at
// acceptance is forwarded from the most recent write when the addresses meet.
// Reset clears the control state and the write pointer; entries not yet
// written since reset read as zero through a wrapped flag, so no clearing
// pass is needed and samples are taken right after reset.
// When rsp stalls, the output register holds its sample; earlier stages keep
// moving until the saturate stage is full, then req_tready drops.
// With effect_enable low samples pass straight through and the delay line
// and write pointer are left alone.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
   parameter int BUFFER_DEPTH = fbecho_pkg::BufferDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fbecho_pkg::SampleW-1:0]   req_tdata,   // sample_in
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fbecho_pkg::SampleW-1:0]   rsp_tdata,   // sample_out
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fbecho_pkg::CsrIndexW-1:0] csr_index,
   input  logic [fbecho_pkg::CsrDataW-1:0]  csr_wdata
);

   import fbecho_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam logic [AW-1:0] LastAddr = AW'(BUFFER_DEPTH - 1);
   localparam logic [AW-1:0] DelayRst =
      AW'((DelayLengthRst > BUFFER_DEPTH - 1) ? BUFFER_DEPTH - 1 : DelayLengthRst);

   // configuration
   logic [AW-1:0]        dly_ff;
   logic [FeedbackW-1:0] fb_ff;
   logic [MixW-1:0]      mix_ff;
   logic                 en_ff;
   logic [DelayW-1:0]    csr_dly;
   logic [FeedbackW-1:0] csr_fb;
   logic [MixW-1:0]      csr_mix;
   logic [AW-1:0]        dly_in;
   logic [FeedbackW-1:0] fb_in;
   logic [MixW-1:0]      mix_in;

   // write pointer
   logic [AW-1:0] wp_ff, wp_in;
   logic          wrapped_ff, wrapped_in;

   // pipeline control
   logic req_acc, out_load, adv, hazard;
   logic [AW:0]   diff;
   logic [AW:0]   rd_full;
   logic [AW-1:0] rd_addr;
   logic          rd_written;

   // multiply stage
   logic          a_valid_ff;
   sample_type    a_sample_ff;
   logic [AW-1:0] a_waddr_ff;
   logic [AW-1:0] a_raddr_ff;
   logic          a_rvalid_ff;
   logic [SampleW-1:0] ram_rd_data;
   sample_type    wet;
   logic [16:0]   dry_coef;
   logic signed [31:0] fb_prod;
   logic signed [33:0] dry_prod;
   logic signed [32:0] wet_prod;

   // saturate stage
   logic          b_valid_ff;
   sample_type    b_sample_ff;
   logic [AW-1:0] b_waddr_ff;
   logic signed [31:0] b_fb_prod_ff;
   logic signed [33:0] b_dry_prod_ff;
   logic signed [32:0] b_wet_prod_ff;
   logic signed [19:0] stored_sum;
   logic signed [19:0] out_sum;
   sample_type    stored;
   sample_type    echo_out;
   logic          ram_wr_en;

   // last write, for forwarding
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   sample_type    fwd_data_ff;

   // output register
   logic          rsp_valid_ff;
   sample_type    rsp_data_ff;

   // configuration writes, values clamped on the way in
   assign csr_ready = 1'b1;
   assign csr_dly   = csr_wdata[DelayW-1:0];
   assign csr_fb    = csr_wdata[FeedbackW-1:0];
   assign csr_mix   = csr_wdata[MixW-1:0];

   always_comb begin
      priority if (csr_dly == '0) begin
         dly_in = AW'(1);
      end else if (32'(csr_dly) > 32'(BUFFER_DEPTH - 1)) begin
         dly_in = LastAddr;
      end else begin
         dly_in = AW'(csr_dly);
      end
      fb_in  = (32'(csr_fb) > 32'(FeedbackLimit)) ? FeedbackW'(FeedbackLimit) : csr_fb;
      mix_in = (32'(csr_mix) > 32'(MixFull)) ? MixW'(MixFull) : csr_mix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff <= DelayRst;
         fb_ff  <= FeedbackW'(FeedbackGainRst);
         mix_ff <= MixW'(MixLevelRst);
         en_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DELAY_LENGTH:  dly_ff <= dly_in;
            CSR_FEEDBACK_GAIN: fb_ff  <= fb_in;
            CSR_MIX_LEVEL:     mix_ff <= mix_in;
            CSR_EFFECT_ENABLE: en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // read address and handshake
   assign diff       = {1'b0, wp_ff} - {1'b0, dly_ff};
   assign rd_full    = diff[AW] ? diff + (AW+1)'(BUFFER_DEPTH) : diff;
   assign rd_addr    = rd_full[AW-1:0];
   assign rd_written = wrapped_ff || !diff[AW];

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign adv        = out_load || !b_valid_ff;
   assign hazard     = a_valid_ff && en_ff && (rd_addr == a_waddr_ff);
   assign req_tready = adv && !hazard;
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      if (req_acc && en_ff) begin
         if (wp_ff == LastAddr) begin
            wp_in      = '0;
            wrapped_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else begin
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
      end
   end

   fbecho_ram #(
      .WIDTH (SampleW),
      .DEPTH (BUFFER_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (b_waddr_ff),
      .wr_data (stored),
      .rd_en   (req_acc),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_sample_ff <= sample_type'(req_tdata);
         a_waddr_ff  <= wp_ff;
         a_raddr_ff  <= rd_addr;
         a_rvalid_ff <= rd_written;
      end
   end

   always_comb begin
      priority if (fwd_valid_ff && (fwd_addr_ff == a_raddr_ff)) begin
         wet = fwd_data_ff;
      end else if (a_rvalid_ff) begin
         wet = sample_type'(ram_rd_data);
      end else begin
         wet = '0;
      end
   end

   assign dry_coef = 17'(MixFull) - {1'b0, mix_ff};
   assign fb_prod  = 32'(wet) * 32'($signed({1'b0, fb_ff}));
   assign dry_prod = 34'(a_sample_ff) * 34'($signed({1'b0, dry_coef}));
   assign wet_prod = 33'(wet) * 33'($signed({1'b0, mix_ff}));

   // saturate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && a_valid_ff) begin
         b_sample_ff   <= a_sample_ff;
         b_waddr_ff    <= a_waddr_ff;
         b_fb_prod_ff  <= fb_prod;
         b_dry_prod_ff <= dry_prod;
         b_wet_prod_ff <= wet_prod;
      end
   end

   assign stored_sum = 20'(b_sample_ff) + 20'($signed(b_fb_prod_ff[31:15]));
   assign out_sum    = 20'($signed(b_dry_prod_ff[33:15]))
                     + 20'($signed(b_wet_prod_ff[32:15]));
   assign stored     = sat16(stored_sum);
   assign echo_out   = en_ff ? sat16(out_sum) : b_sample_ff;
   assign ram_wr_en  = b_valid_ff && en_ff && out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (ram_wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         fwd_addr_ff <= b_waddr_ff;
         fwd_data_ff <= stored;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && b_valid_ff) begin
         rsp_data_ff <= echo_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // with the effect enabled, no sample is taken whose read entry the one in the multiply stage still has to write
   a_no_raw_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc && en_ff |-> !(a_valid_ff && (a_waddr_ff == rd_addr)))
      else $error("accepted sample reads an entry still being computed");

   // once the pointer wrapped, every entry is written
   a_wrapped_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrapped flag dropped");

   // bypass leaves the write pointer alone
   a_bypass_hold: assert property (@(posedge clock) disable iff (reset)
      !en_ff |=> $stable(wp_ff))
      else $error("write pointer moved in bypass");

   // a blocked saturate stage keeps its sample and issues no write
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_load |=> b_valid_ff && $stable(b_waddr_ff) && !$past(ram_wr_en))
      else $error("saturate stage lost or wrote a blocked sample");

endmodule

// ===== tb/tb_feedback_echo_delay.sv =====
// ----------------------------------------------------------------------------
// tb_feedback_echo_delay
// self-checking bench for the feedback echo delay line
// ----------------------------------------------------------------------------
// A software copy of the echo holds its own delay line, write pointer and
// registers. It predicts one output per accepted input sample. Each output
// transaction is compared with the oldest prediction.
// A short directed part comes first: sample extremes, bypass, zero and full
// delay, clamped feedback and mix, masked register data and an unused
// register index. Random phases follow, each with its own register setting
// and its own mix of idle cycles on the input and output sides.
// Registers are written only once every predicted output has arrived.
// ----------------------------------------------------------------------------
module tb_feedback_echo_delay;
   import fbecho_pkg::*;

   localparam int WatchdogLimit = 2000;
   localparam int LineDepth     = BufferDepthDefault;

   class echo_tracker;
      shortint                line_mem [LineDepth];
      int unsigned            wr_ptr;
      logic [DelayW-1:0]      delay_reg;
      logic [FeedbackW-1:0]   gain_reg;
      logic [MixW-1:0]        mix_reg;
      logic                   enable_reg;
      shortint                pending_out [$];
      int                     errors;

      function new();
         foreach (line_mem[i]) line_mem[i] = 0;
         wr_ptr     = 0;
         delay_reg  = DelayW'(DelayLengthRst);
         gain_reg   = FeedbackW'(FeedbackGainRst);
         mix_reg    = MixW'(MixLevelRst);
         enable_reg = 1'b1;
         errors     = 0;
      endfunction

      function shortint clip16(longint v);
         if (v > 32767) return 16'sh7fff;
         if (v < -32768) return 16'sh8000;
         return shortint'(v);
      endfunction

      function void write_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] val);
         case (idx)
            CSR_DELAY_LENGTH:  delay_reg = val[DelayW-1:0];
            CSR_FEEDBACK_GAIN: gain_reg = val[FeedbackW-1:0];
            CSR_MIX_LEVEL:     mix_reg = val[MixW-1:0];
            CSR_EFFECT_ENABLE: enable_reg = val[0];
            default: ;
         endcase
      endfunction

      function void take_sample(logic signed [SampleW-1:0] x);
         int unsigned dly;
         int unsigned rd_ptr;
         longint      gain;
         longint      wet_share;
         longint      wet;
         if (!enable_reg) begin
            pending_out.push_back(x);
            return;
         end
         dly = delay_reg;
         if (dly == 0) dly = 1;
         if (dly > LineDepth - 1) dly = LineDepth - 1;
         gain      = (gain_reg > FeedbackLimit) ? FeedbackLimit : gain_reg;
         wet_share = (mix_reg > MixFull) ? MixFull : mix_reg;
         rd_ptr    = (wr_ptr + LineDepth - dly) % LineDepth;
         wet       = line_mem[rd_ptr];
         line_mem[wr_ptr] = clip16(longint'(x) + ((wet * gain) >>> 15));
         wr_ptr = (wr_ptr + 1) % LineDepth;
         pending_out.push_back(clip16(((longint'(x) * (MixFull - wet_share)) >>> 15)
                                      + ((wet * wet_share) >>> 15)));
      endfunction

      function void check_output(logic signed [SampleW-1:0] got);
         shortint want;
         if (pending_out.size() == 0) begin
            errors++;
            if (errors <= 10) $display("output %0d arrived with no sample pending", got);
         end else begin
            want = pending_out.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("output mismatch: expected %0d, got %0d", want, got);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SampleW-1:0]     req_tdata;    // sample_in
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [SampleW-1:0]     rsp_tdata;    // sample_out
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CsrIndexW-1:0]   csr_index;
   logic [CsrDataW-1:0]    csr_wdata;

   bit                     tx_idle_on;
   bit                     rx_idle_on;
   echo_tracker            echo_calc;

   feedback_echo_delay i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic send_sample(logic [SampleW-1:0] x);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (req_tready !== 1'b1);
      echo_calc.take_sample(x);
   endtask

   task automatic write_reg(logic [CsrIndexW-1:0] idx, logic [CsrDataW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      echo_calc.write_reg(idx, val);
   endtask

   // stop sending and wait for every predicted output
   task automatic settle();
      req_tvalid <= 1'b0;
      while (echo_calc.pending_out.size() != 0) @(posedge clock);
   endtask

   function automatic logic [SampleW-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: pick_sample = 16'h7fff;
         1: pick_sample = 16'h8000;
         2: pick_sample = 16'($urandom_range(0, 511) - 256);
         default: pick_sample = 16'($urandom);
      endcase
   endfunction

   task automatic random_setup();
      logic [CsrDataW-1:0] val;
      case ($urandom_range(0, 7))
         0: val = 16'd0;
         1: val = 16'd1;
         2: val = 16'h1fff;
         3: val = 16'($urandom);
         default: val = 16'($urandom_range(1, 64));
      endcase
      write_reg(CSR_DELAY_LENGTH, val);
      case ($urandom_range(0, 7))
         0: val = 16'd0;
         1: val = 16'(FeedbackLimit);
         2: val = 16'(FeedbackLimit + 1);
         3: val = 16'hffff;
         4: val = 16'($urandom);
         default: val = 16'($urandom_range(0, FeedbackLimit));
      endcase
      write_reg(CSR_FEEDBACK_GAIN, val);
      case ($urandom_range(0, 7))
         0: val = 16'd0;
         1: val = 16'(MixFull);
         2: val = 16'(MixFull + 1);
         3: val = 16'hffff;
         4: val = 16'($urandom);
         default: val = 16'($urandom_range(0, MixFull));
      endcase
      write_reg(CSR_MIX_LEVEL, val);
      val = 16'($urandom);
      val[0] = ($urandom_range(0, 4) != 0);
      write_reg(CSR_EFFECT_ENABLE, val);
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CsrIndexW'($urandom_range(4, 15)), 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [SampleW-1:0] corner_in [7];
      int                 n_items;
      int                 mode;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      echo_calc  = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings, long delay so the wet path reads empty entries
      corner_in = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa};
      foreach (corner_in[i]) send_sample(corner_in[i]);
      settle();

      // zero delay, feedback and mix above their limits
      write_reg(CSR_DELAY_LENGTH, 16'd0);
      write_reg(CSR_FEEDBACK_GAIN, 16'h7fff);
      write_reg(CSR_MIX_LEVEL, 16'hffff);
      csr_valid <= 1'b0;
      repeat (3) send_sample(16'h7fff);
      repeat (3) send_sample(16'h8000);
      settle();

      // dry only, delay data with bits above the field
      write_reg(CSR_DELAY_LENGTH, 16'he001);
      write_reg(CSR_FEEDBACK_GAIN, 16'd0);
      write_reg(CSR_MIX_LEVEL, 16'd0);
      csr_valid <= 1'b0;
      send_sample(16'd12345);
      send_sample(16'hffff);
      settle();

      // bypass and a write to an unused index
      write_reg(CSR_EFFECT_ENABLE, 16'hfffe);
      write_reg(4'd9, 16'hffff);
      csr_valid <= 1'b0;
      send_sample(16'h7fff);
      send_sample(16'h8000);
      send_sample(16'd100);
      settle();

      // longest delay, top feedback, fully wet
      write_reg(CSR_EFFECT_ENABLE, 16'd1);
      write_reg(CSR_DELAY_LENGTH, 16'h1fff);
      write_reg(CSR_FEEDBACK_GAIN, 16'(FeedbackLimit));
      write_reg(CSR_MIX_LEVEL, 16'(MixFull));
      csr_valid <= 1'b0;
      send_sample(16'd1000);
      send_sample(-16'sd1000);
      settle();

      for (int p = 0; p < 12; p++) begin
         random_setup();
         mode = (p < 4) ? p : $urandom_range(0, 3);
         tx_idle_on = mode[0];
         rx_idle_on = mode[1];
         n_items = $urandom_range(100, 166);
         for (int k = 0; k < n_items; k++) begin
            if (p == 5 && k == n_items / 2) settle();
            send_sample(pick_sample());
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (echo_calc.pending_out.size() != 0) begin
         $display("%0d outputs never arrived", echo_calc.pending_out.size());
      end
      if (echo_calc.errors == 0 && echo_calc.pending_out.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : output_side
      int gap;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = rx_idle_on ? $urandom_range(0, 18) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         echo_calc.check_output(rsp_tdata);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      wait (reset == 1'b0);
      while (quiet < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no transaction for %0d cycles", WatchdogLimit);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
